// ===== hw/rtl/bsew_pkg.sv =====
// ============================================================================
// bsew_pkg - shared types and constants for the bson element walker
// Phase codes, bson type codes, result kinds and the fixed value size table.
// ============================================================================
`default_nettype none

package bsew_pkg;

    // offset arithmetic width (document length must fit below 2^OFFSET_BITS)
    localparam int OFFSET_BITS = 16;
    localparam int OFF_W       = OFFSET_BITS;
    localparam int RES_OFF_W   = 16;

    // walker phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEN    = 3'd1;
    localparam logic [2:0] PH_TYPE   = 3'd2;
    localparam logic [2:0] PH_NAME   = 3'd3;
    localparam logic [2:0] PH_PREFIX = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_REGEX  = 3'd6;
    localparam logic [2:0] PH_DONE   = 3'd7;

    // result kinds
    localparam logic [1:0] K_ELEM = 2'd0;
    localparam logic [1:0] K_TERM = 2'd1;
    localparam logic [1:0] K_BAD  = 2'd2;

    // bson type codes
    localparam logic [7:0] T_END     = 8'h00;
    localparam logic [7:0] T_DOUBLE  = 8'h01;
    localparam logic [7:0] T_STRING  = 8'h02;
    localparam logic [7:0] T_DOC     = 8'h03;
    localparam logic [7:0] T_ARRAY   = 8'h04;
    localparam logic [7:0] T_BINARY  = 8'h05;
    localparam logic [7:0] T_UNDEF   = 8'h06;
    localparam logic [7:0] T_OID     = 8'h07;
    localparam logic [7:0] T_BOOL    = 8'h08;
    localparam logic [7:0] T_DATE    = 8'h09;
    localparam logic [7:0] T_NULL    = 8'h0a;
    localparam logic [7:0] T_REGEX   = 8'h0b;
    localparam logic [7:0] T_DBPTR   = 8'h0c;
    localparam logic [7:0] T_CODE    = 8'h0d;
    localparam logic [7:0] T_SYMBOL  = 8'h0e;
    localparam logic [7:0] T_CODE_WS = 8'h0f;
    localparam logic [7:0] T_INT32   = 8'h10;
    localparam logic [7:0] T_TSTAMP  = 8'h11;
    localparam logic [7:0] T_INT64   = 8'h12;
    localparam logic [7:0] T_DEC128  = 8'h13;
    localparam logic [7:0] T_LAST    = T_DEC128;

    // walker state
    typedef struct packed {
        logic [2:0]       phase;
        logic [OFF_W-1:0] position;
        logic [OFF_W-1:0] doc_end;
        logic [OFF_W-1:0] elem_start;
        logic [7:0]       cur_type;
        logic [31:0]      len_gather;
        logic [OFF_W-1:0] skip_left;
        logic [OFF_W-1:0] value_start;
        logic [1:0]       strings_left;
    } t_walk_state;

    // one result beat
    typedef struct packed {
        logic [1:0]           kind;
        logic [15:0]          vlen;
        logic [7:0]           etype;
        logic [RES_OFF_W-1:0] offset;
    } t_beat;

    typedef struct packed {
        logic  valid;
        t_beat beat;
    } t_result;

    typedef struct packed {
        logic       is_fixed;
        logic [4:0] size;
    } t_fixed;

    // fixed value sizes; is_fixed low for prefixed and regex types
    function automatic t_fixed fixed_size(input logic [7:0] t);
        t_fixed f;
        f.is_fixed = 1'b1;
        case (t) inside
            T_DOUBLE, T_DATE, T_TSTAMP, T_INT64: f.size = 5'd8;
            T_UNDEF, T_NULL:                     f.size = 5'd0;
            T_OID:                               f.size = 5'd12;
            T_BOOL:                              f.size = 5'd1;
            T_INT32:                             f.size = 5'd4;
            T_DEC128:                            f.size = 5'd16;
            default: begin
                f.is_fixed = 1'b0;
                f.size     = 5'd0;
            end
        endcase
        return f;
    endfunction

    // offset to result field width
    function automatic logic [RES_OFF_W-1:0] to_res_off(input logic [OFF_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[RES_OFF_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bson_element_walker_core.sv =====
// ============================================================================
// bson_element_walker_core - streaming walker over top-level bson elements
// Takes one document byte per beat and reports each element, the terminator
// or a malformed document as a result beat.
// ============================================================================
// usage:
//   slave side: one document byte per beat in tdata; tuser marks the first
//   byte of a new document and restarts the walk from any state.
//   master side: tuser carries the result kind (element, terminator,
//   malformed); tdata carries element offset, type and value length.
//   at most one result beat per input byte.
// timing:
//   a byte is held in the input register and walked there; its result is
//   pushed into a two-entry buffer once that has space, and tvalid comes
//   from the buffer's occupancy register. one byte per cycle is taken while
//   the buffer has space, set by the single state update done for each byte.
// reset:
//   synchronous, active low; the walker idles and ignores bytes until one
//   marked as first arrives. the result buffer is emptied.
// stall:
//   when the master side stalls the buffer fills; with both entries taken
//   the input register holds its byte and tready drops, rising again the
//   cycle after a beat leaves.
// ============================================================================
`default_nettype none

module bson_element_walker_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] first_byte
    // master side
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [15:0] element_offset,
                                               // [23:16] element_type,
                                               // [39:24] value_length
    output logic [1:0]       o_m_axis_tuser    // [1:0] kind
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_first;
    bsew_pkg::t_walk_state r_state;
    bsew_pkg::t_walk_state n_state;
    bsew_pkg::t_result     step_res;
    bsew_pkg::t_beat       out_beat;
    logic                  buf_space;
    logic                  advance;
    logic                  in_take;

    assign advance         = r_in_valid && buf_space;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_first <= i_s_axis_tuser;
        end
    end

    // walk step
    bsew_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_first  (r_in_first),
        .o_state  (n_state),
        .o_result (step_res)
    );

    // walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: bsew_pkg::PH_IDLE, default: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result buffer
    bsew_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance && step_res.valid),
        .i_beat  (step_res.beat),
        .o_space (buf_space),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_beat  (out_beat)
    );

    assign o_m_axis_tdata = {out_beat.vlen, out_beat.etype, out_beat.offset};
    assign o_m_axis_tuser = out_beat.kind;

    // checks
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == bsew_pkg::K_ELEM ||
                             o_m_axis_tuser == bsew_pkg::K_TERM ||
                             o_m_axis_tuser == bsew_pkg::K_BAD))
        else $error("illegal result kind");

    a_non_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != bsew_pkg::K_ELEM)
            |-> o_m_axis_tdata[39:16] == '0)
        else $error("terminator or malformed beat carries type or length");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_first &&
         (r_state.phase == bsew_pkg::PH_IDLE || r_state.phase == bsew_pkg::PH_DONE))
            |-> !step_res.valid)
        else $error("result produced while idle or done");

    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && step_res.valid && step_res.beat.kind != bsew_pkg::K_ELEM)
            |=> r_state.phase == bsew_pkg::PH_DONE)
        else $error("walker did not stop after terminator or fault");

endmodule

`default_nettype wire

// ===== hw/rtl/bsew_step.sv =====
// ============================================================================
// bsew_step - next-state and result logic for one document byte
// Pure combinational walk step: takes the current state and one byte, gives
// the next state and at most one result.
// ============================================================================
`default_nettype none

module bsew_step (
    input  wire bsew_pkg::t_walk_state i_state,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_first,
    output bsew_pkg::t_walk_state      o_state,
    output bsew_pkg::t_result          o_result
);

    localparam int OFF_W = bsew_pkg::OFF_W;

    bsew_pkg::t_walk_state s;
    bsew_pkg::t_walk_state n;
    bsew_pkg::t_result     res;
    bsew_pkg::t_fixed      fx;
    logic [OFF_W-1:0]      idx;
    logic [OFF_W-1:0]      rel;
    logic [31:0]           lg;
    logic [32:0]           rest;
    logic [33:0]           reach;
    logic                  at_end;
    logic                  bad;

    always_comb begin
        // a first byte restarts the walk: state cleared, length gathering begins
        s = i_state;
        if (i_first) begin
            s       = '0;
            s.phase = bsew_pkg::PH_LEN;
        end
        n      = s;
        res    = '0;
        idx    = s.position;
        rel    = idx - s.value_start;
        lg     = '0;
        rest   = '0;
        reach  = '0;
        bad    = 1'b0;
        fx     = bsew_pkg::fixed_size(s.cur_type);
        at_end = ({1'b0, idx} + (OFF_W+1)'(1)) >= {1'b0, s.doc_end};

        if (s.phase != bsew_pkg::PH_IDLE && s.phase != bsew_pkg::PH_DONE) begin
            n.position = idx + OFF_W'(1);

            if (s.phase == bsew_pkg::PH_LEN) begin
                // gather the little-endian document length
                lg           = s.len_gather | (32'(i_byte) << {idx[1:0], 3'b000});
                n.len_gather = lg;
                if (idx[1:0] == 2'd3) begin
                    if (lg[31] || lg < 32'd5 || lg[31:OFF_W] != '0) begin
                        bad = 1'b1;
                    end else begin
                        n.doc_end = lg[OFF_W-1:0];
                        n.phase   = bsew_pkg::PH_TYPE;
                    end
                end
            end else if (at_end) begin
                // last byte must be the terminator
                if (s.phase == bsew_pkg::PH_TYPE && i_byte == bsew_pkg::T_END) begin
                    n.phase          = bsew_pkg::PH_DONE;
                    res.valid        = 1'b1;
                    res.beat.kind    = bsew_pkg::K_TERM;
                    res.beat.offset  = bsew_pkg::to_res_off(idx);
                end else begin
                    bad = 1'b1;
                end
            end else begin
                unique case (s.phase)
                    bsew_pkg::PH_TYPE: begin
                        n.elem_start = idx;
                        n.cur_type   = i_byte;
                        if (i_byte == bsew_pkg::T_END || i_byte > bsew_pkg::T_LAST) begin
                            bad = 1'b1;
                        end else begin
                            n.phase = bsew_pkg::PH_NAME;
                        end
                    end
                    bsew_pkg::PH_NAME: begin
                        if (i_byte == 8'h00) begin
                            n.value_start = idx + OFF_W'(1);
                            if (s.cur_type == bsew_pkg::T_REGEX) begin
                                n.strings_left = 2'd2;
                                n.phase        = bsew_pkg::PH_REGEX;
                            end else if (!fx.is_fixed) begin
                                n.len_gather = '0;
                                n.phase      = bsew_pkg::PH_PREFIX;
                            end else if (fx.size == 5'd0) begin
                                n.phase = bsew_pkg::PH_TYPE;
                                res.valid = 1'b1;
                            end else begin
                                n.skip_left = OFF_W'(fx.size);
                                n.phase     = bsew_pkg::PH_SKIP;
                            end
                        end
                    end
                    bsew_pkg::PH_PREFIX: begin
                        // gather the value length prefix, then size the value
                        lg           = s.len_gather | (32'(i_byte) << {rel[1:0], 3'b000});
                        n.len_gather = lg;
                        if (rel[1:0] == 2'd3) begin
                            rest = {1'b0, lg};
                            case (s.cur_type) inside
                                bsew_pkg::T_DOC, bsew_pkg::T_ARRAY, bsew_pkg::T_CODE_WS:
                                    rest = {1'b0, lg} - 33'd4;
                                bsew_pkg::T_BINARY: rest = {1'b0, lg} + 33'd1;
                                bsew_pkg::T_DBPTR:  rest = {1'b0, lg} + 33'd12;
                                default:            rest = {1'b0, lg};
                            endcase
                            reach = 34'(idx) + {1'b0, rest} + 34'd2;
                            if (lg[31]) begin
                                bad = 1'b1;
                            end else if ((s.cur_type == bsew_pkg::T_DOC ||
                                          s.cur_type == bsew_pkg::T_ARRAY ||
                                          s.cur_type == bsew_pkg::T_CODE_WS) &&
                                         lg < 32'd4) begin
                                bad = 1'b1;
                            end else if (reach > 34'(s.doc_end)) begin
                                bad = 1'b1;
                            end else if (rest == '0) begin
                                n.phase   = bsew_pkg::PH_TYPE;
                                res.valid = 1'b1;
                            end else begin
                                n.skip_left = rest[OFF_W-1:0];
                                n.phase     = bsew_pkg::PH_SKIP;
                            end
                        end
                    end
                    bsew_pkg::PH_SKIP: begin
                        n.skip_left = s.skip_left - OFF_W'(1);
                        if (n.skip_left == '0) begin
                            n.phase   = bsew_pkg::PH_TYPE;
                            res.valid = 1'b1;
                        end
                    end
                    bsew_pkg::PH_REGEX: begin
                        if (i_byte == 8'h00) begin
                            n.strings_left = s.strings_left - 2'd1;
                            if (n.strings_left == 2'd0) begin
                                n.phase   = bsew_pkg::PH_TYPE;
                                res.valid = 1'b1;
                            end
                        end
                    end
                    default: n.phase = bsew_pkg::PH_DONE;
                endcase

                // element complete
                if (res.valid) begin
                    res.beat.kind   = bsew_pkg::K_ELEM;
                    res.beat.offset = bsew_pkg::to_res_off(n.elem_start);
                    res.beat.etype  = n.cur_type;
                    res.beat.vlen   = 16'(bsew_pkg::to_res_off(idx + OFF_W'(1) - n.value_start));
                end
            end

            // malformed document
            if (bad) begin
                n.phase         = bsew_pkg::PH_DONE;
                res.valid       = 1'b1;
                res.beat        = '0;
                res.beat.kind   = bsew_pkg::K_BAD;
                res.beat.offset = bsew_pkg::to_res_off(idx);
            end
        end

        o_state  = n;
        o_result = res;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsew_out_buf.sv =====
// ============================================================================
// bsew_out_buf - two-entry result buffer
// Holds result beats so the walker keeps taking bytes while the receiver
// stalls; space is derived from registers only.
// ============================================================================
`default_nettype none

module bsew_out_buf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bsew_pkg::t_beat i_beat,
    output logic                o_space,
    output logic                o_valid,
    input  wire logic           i_ready,
    output bsew_pkg::t_beat     o_beat
);

    bsew_pkg::t_beat r_slot [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    logic            pop;

    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_beat  = r_slot[r_rd];
    assign pop     = o_valid && i_ready;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_beat;
        end
    end

endmodule

`default_nettype wire
